FILE: src/psll_pkg.sv
// Shared constants and types for the polar stereographic lat/long to x/y core.
// Used by the top level, psll_reduce, psll_horner_cell, psll_trig and psll_axis; depends on nothing.
package psll_pkg;

	localparam int unsigned SIN_TERMS = 5;
	localparam int unsigned COS_TERMS = 6;
	localparam int unsigned CELL_LAT  = 3;
	localparam int unsigned SIN_DIV [SIN_TERMS] = '{110, 72, 42, 20, 6};
	localparam int unsigned COS_DIV [COS_TERMS] = '{132, 90, 56, 30, 12, 2};

	localparam int unsigned TRIG_LAT   = 1 + CELL_LAT * COS_TERMS;
	localparam int unsigned REDUCE_LAT = 6;
	localparam int unsigned DIV_STEPS  = 48;
	localparam int unsigned AXIS_LAT   = 7;

	localparam int unsigned TRIG_W = 31;
	localparam int unsigned X_W    = 30;
	localparam int unsigned REM_W  = 32;
	localparam int unsigned NQ_W   = 48;

	localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
	localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;
	localparam logic [31:0] RECIP_90    = 32'd47721858;
	localparam logic [47:0] R_LIMIT     = 48'h8000_0000_0000;

	localparam int unsigned CFG_ADDR_W = 5;
	localparam logic [2:0] REG_RADIAL_GAIN = 3'd0;
	localparam logic [2:0] REG_X_OFFSET    = 3'd1;
	localparam logic [2:0] REG_Y_OFFSET    = 3'd2;
	localparam logic [2:0] REG_X_INV_SIZE  = 3'd3;
	localparam logic [2:0] REG_Y_INV_SIZE  = 3'd4;

	localparam logic [31:0] RST_RADIAL_GAIN = 32'd48886579;
	localparam logic [15:0] RST_X_OFFSET    = 16'd6000;
	localparam logic [15:0] RST_Y_OFFSET    = 16'd5000;
	localparam logic [31:0] RST_X_INV_SIZE  = 32'd5726623;
	localparam logic [31:0] RST_Y_INV_SIZE  = 32'd6871948;

	typedef struct packed {
		logic [15:0] off;
		logic [31:0] inv;
	} axis_cfg_t;

	typedef struct packed {
		logic valid;
		logic lon_neg;
	} sb_reduce_t;

	typedef struct packed {
		logic       valid;
		logic       lon_neg;
		logic [1:0] lat_q;
		logic       lat_fold;
		logic [1:0] lon_q;
		logic       lon_fold;
	} sb_trig_t;

	typedef struct packed {
		logic        valid;
		logic        ovf;
		logic [30:0] ls;
		logic        lsn;
		logic [30:0] lc;
		logic        lcn;
	} sb_div_t;

	typedef struct packed {
		logic valid;
		logic sat;
	} sb_axis_t;

endpackage

FILE: src/polar_stereo_latlong_to_xy_core.sv
// Top level of the southern polar stereographic lat/long to x/y projection core.
// Depends on psll_pkg, psll_delay, psll_reduce, psll_trig, psll_div_cell, psll_axis.
//
//   channel | signals                                      | transaction
//   --------+----------------------------------------------+---------------------------
//   input   | in_valid, in_ready, lat_deg, lon_deg         | valid & ready at clk edge
//   output  | out_valid, out_ready, x_rel, y_rel, saturated | valid & ready at clk edge
//   config  | psel, penable, pwrite, paddr, pwdata ...     | psel & penable & pwrite
//
// One transaction enters per cycle while the pipeline is not held; a result passes
// through 84 register stages.
// The latency is set by the 48-cell radius divider and the Horner trig chains.
// The whole pipeline advances together; it holds while a result waits at the output.
// Reset clears the valid bits and loads the configuration registers with defaults.
module polar_stereo_latlong_to_xy_core #(
	parameter int ANGLE_FRAC_BITS = 16,
	parameter int OUT_FRAC_BITS   = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [23:0]                lat_deg,
	input  logic signed [24:0]                lon_deg,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [31:0]                x_rel,
	output logic signed [31:0]                y_rel,
	output logic                              saturated,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [psll_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	localparam logic [31:0] QUARTER = 32'd90 << ANGLE_FRAC_BITS;

	logic [31:0] radial_gain_q, x_inv_size_q, y_inv_size_q;
	logic [15:0] x_offset_q, y_offset_q;
	logic [2:0]  reg_idx;
	logic        wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr      = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radial_gain_q <= psll_pkg::RST_RADIAL_GAIN;
			x_offset_q    <= psll_pkg::RST_X_OFFSET;
			y_offset_q    <= psll_pkg::RST_Y_OFFSET;
			x_inv_size_q  <= psll_pkg::RST_X_INV_SIZE;
			y_inv_size_q  <= psll_pkg::RST_Y_INV_SIZE;
		end else if (wr) begin
			unique case (reg_idx)
				psll_pkg::REG_RADIAL_GAIN: radial_gain_q <= pwdata;
				psll_pkg::REG_X_OFFSET:    x_offset_q    <= pwdata[15:0];
				psll_pkg::REG_Y_OFFSET:    y_offset_q    <= pwdata[15:0];
				psll_pkg::REG_X_INV_SIZE:  x_inv_size_q  <= pwdata;
				psll_pkg::REG_Y_INV_SIZE:  y_inv_size_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			psll_pkg::REG_RADIAL_GAIN: prdata = radial_gain_q;
			psll_pkg::REG_X_OFFSET:    prdata = 32'(x_offset_q);
			psll_pkg::REG_Y_OFFSET:    prdata = 32'(y_offset_q);
			psll_pkg::REG_X_INV_SIZE:  prdata = x_inv_size_q;
			psll_pkg::REG_Y_INV_SIZE:  prdata = y_inv_size_q;
			default:                   prdata = 32'd0;
		endcase
	end

	// Pipeline advance: everything moves unless a finished result is held.
	logic en;
	logic valid_s84;

	assign en       = !valid_s84 || out_ready;
	assign in_ready = en;

	// Stage 1: latitude magnitude, clamp to the pole, colatitude; longitude magnitude.
	logic [24:0] lat_ext, lat_abs;
	logic [25:0] lon_ext, lon_abs;
	logic [31:0] alat, colat_s1, lonmag_s1;
	logic        valid_s1, lonneg_s1;

	assign lat_ext = {lat_deg[23], lat_deg};
	assign lat_abs = lat_deg[23] ? -lat_ext : lat_ext;
	assign lon_ext = {lon_deg[24], lon_deg};
	assign lon_abs = lon_deg[24] ? -lon_ext : lon_ext;
	assign alat    = (32'(lat_abs) > QUARTER) ? QUARTER : 32'(lat_abs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			colat_s1  <= QUARTER - alat;
			lonmag_s1 <= 32'(lon_abs);
			lonneg_s1 <= lon_deg[24];
		end
	end

	// Stages 2 to 7: angle reduction.
	logic [29:0] lat_x_s7, lon_x_s7;
	logic [1:0]  lat_q_s7, lon_q_s7;
	logic        lat_fold_s7, lon_fold_s7;
	psll_pkg::sb_reduce_t sb_s1, sb_s7;

	assign sb_s1.valid   = valid_s1;
	assign sb_s1.lon_neg = lonneg_s1;

	psll_reduce #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lat_reduce (
		.clk  (clk),
		.en   (en),
		.a    (colat_s1),
		.x    (lat_x_s7),
		.q    (lat_q_s7),
		.fold (lat_fold_s7)
	);

	psll_reduce #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lon_reduce (
		.clk  (clk),
		.en   (en),
		.a    (lonmag_s1),
		.x    (lon_x_s7),
		.q    (lon_q_s7),
		.fold (lon_fold_s7)
	);

	psll_delay #(.WIDTH($bits(psll_pkg::sb_reduce_t)), .DEPTH(psll_pkg::REDUCE_LAT)) u_sb1 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      (sb_s1),
		.q      (sb_s7)
	);

	// Stages 8 to 26: series evaluation.
	logic [30:0] lat_sin_s26, lat_cos_s26, lon_sin_s26, lon_cos_s26;
	psll_pkg::sb_trig_t sb_s7t, sb_s26;

	assign sb_s7t.valid    = sb_s7.valid;
	assign sb_s7t.lon_neg  = sb_s7.lon_neg;
	assign sb_s7t.lat_q    = lat_q_s7;
	assign sb_s7t.lat_fold = lat_fold_s7;
	assign sb_s7t.lon_q    = lon_q_s7;
	assign sb_s7t.lon_fold = lon_fold_s7;

	psll_trig u_lat_trig (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.x      (lat_x_s7),
		.sin_x  (lat_sin_s26),
		.cos_x  (lat_cos_s26)
	);

	psll_trig u_lon_trig (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.x      (lon_x_s7),
		.sin_x  (lon_sin_s26),
		.cos_x  (lon_cos_s26)
	);

	psll_delay #(.WIDTH($bits(psll_pkg::sb_trig_t)), .DEPTH(psll_pkg::TRIG_LAT)) u_sb2 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      (sb_s7t),
		.q      (sb_s26)
	);

	// Stage 27: quadrant mapping and the numerator of the radius.
	logic [30:0] lat_s0, lat_c0, lon_s0, lon_c0, ts, tc;
	logic [30:0] ls_s27, lc_s27, tc_s27;
	logic        lsn_s27, lcn_s27, valid_s27;
	logic [61:0] num_s27;

	assign lat_s0 = sb_s26.lat_fold ? lat_cos_s26 : lat_sin_s26;
	assign lat_c0 = sb_s26.lat_fold ? lat_sin_s26 : lat_cos_s26;
	assign lon_s0 = sb_s26.lon_fold ? lon_cos_s26 : lon_sin_s26;
	assign lon_c0 = sb_s26.lon_fold ? lon_sin_s26 : lon_cos_s26;
	assign ts     = sb_s26.lat_q[0] ? lat_c0 : lat_s0;
	assign tc     = sb_s26.lat_q[0] ? lat_s0 : lat_c0;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s27 <= 62'(radial_gain_q) * 62'(ts);
			tc_s27  <= tc;
			ls_s27  <= sb_s26.lon_q[0] ? lon_c0 : lon_s0;
			lc_s27  <= sb_s26.lon_q[0] ? lon_s0 : lon_c0;
			lsn_s27 <= sb_s26.lon_q[1] ^ sb_s26.lon_neg;
			lcn_s27 <= sb_s26.lon_q[1] ^ sb_s26.lon_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s27 <= 1'b0;
		end else if (en) begin
			valid_s27 <= sb_s26.valid;
		end
	end

	// Stage 28: overflow check. A quotient of 2^48 or more, or a zero cosine, clips r.
	logic [31:0] rem_s28;
	logic [47:0] nq_s28;
	logic [30:0] d_s28;
	psll_pkg::sb_div_t sb_s28, sb_s76;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s28 <= 32'(num_s27[61:48]);
			nq_s28  <= num_s27[47:0];
			d_s28   <= tc_s27;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_s28 <= '0;
		end else if (en) begin
			sb_s28.valid <= valid_s27;
			sb_s28.ovf   <= 31'(num_s27[61:48]) >= tc_s27;
			sb_s28.ls    <= ls_s27;
			sb_s28.lsn   <= lsn_s27;
			sb_s28.lc    <= lc_s27;
			sb_s28.lcn   <= lcn_s27;
		end
	end

	// Stages 29 to 76: one quotient bit per divider cell.
	logic [31:0] rem_w [psll_pkg::DIV_STEPS+1];
	logic [47:0] nq_w  [psll_pkg::DIV_STEPS+1];
	logic [30:0] d_w   [psll_pkg::DIV_STEPS+1];

	assign rem_w[0] = rem_s28;
	assign nq_w[0]  = nq_s28;
	assign d_w[0]   = d_s28;

	for (genvar gi = 0; gi < psll_pkg::DIV_STEPS; gi++) begin : g_div
		psll_div_cell u_cell (
			.clk     (clk),
			.en      (en),
			.rem_in  (rem_w[gi]),
			.nq_in   (nq_w[gi]),
			.d_in    (d_w[gi]),
			.rem_out (rem_w[gi+1]),
			.nq_out  (nq_w[gi+1]),
			.d_out   (d_w[gi+1])
		);
	end

	psll_delay #(.WIDTH($bits(psll_pkg::sb_div_t)), .DEPTH(psll_pkg::DIV_STEPS)) u_sb3 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      (sb_s28),
		.q      (sb_s76)
	);

	// Stage 77: radius limit.
	logic [47:0] r_s77, q_div;
	logic [30:0] ls_s77, lc_s77;
	logic        lsn_s77, lcn_s77, clip;
	psll_pkg::sb_axis_t sb_s77, sb_s84;

	assign q_div = nq_w[psll_pkg::DIV_STEPS];
	assign clip  = sb_s76.ovf || (q_div > psll_pkg::R_LIMIT);

	always_ff @(posedge clk) begin
		if (en) begin
			r_s77      <= clip ? psll_pkg::R_LIMIT : q_div;
			ls_s77     <= sb_s76.ls;
			lsn_s77    <= sb_s76.lsn;
			lc_s77     <= sb_s76.lc;
			lcn_s77    <= sb_s76.lcn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_s77 <= '0;
		end else if (en) begin
			sb_s77.valid <= sb_s76.valid;
			sb_s77.sat   <= clip;
		end
	end

	// Stages 78 to 84: both map axes.
	psll_pkg::axis_cfg_t x_cfg, y_cfg;
	logic [31:0] x_val, y_val;
	logic        x_sat, y_sat;

	assign x_cfg.off = x_offset_q;
	assign x_cfg.inv = x_inv_size_q;
	assign y_cfg.off = y_offset_q;
	assign y_cfg.inv = y_inv_size_q;

	psll_axis #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_x_axis (
		.clk (clk),
		.en  (en),
		.r   (r_s77),
		.tm  (ls_s77),
		.tn  (lsn_s77),
		.cfg (x_cfg),
		.val (x_val),
		.sat (x_sat)
	);

	psll_axis #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_y_axis (
		.clk (clk),
		.en  (en),
		.r   (r_s77),
		.tm  (lc_s77),
		.tn  (lcn_s77),
		.cfg (y_cfg),
		.val (y_val),
		.sat (y_sat)
	);

	psll_delay #(.WIDTH($bits(psll_pkg::sb_axis_t)), .DEPTH(psll_pkg::AXIS_LAT)) u_sb4 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      (sb_s77),
		.q      (sb_s84)
	);

	assign valid_s84 = sb_s84.valid;
	assign out_valid = valid_s84;
	assign x_rel     = x_val;
	assign y_rel     = y_val;
	assign saturated = sb_s84.sat | x_sat | y_sat;

endmodule

FILE: src/psll_delay.sv
// Delay line with a common advance enable, used to carry side data past a unit.
// Depends on nothing.
module psll_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] pipe_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) pipe_q[i] <= '0;
		end else if (en) begin
			pipe_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) pipe_q[i] <= pipe_q[i-1];
		end
	end

	assign q = pipe_q[DEPTH-1];

endmodule

FILE: src/psll_reduce.sv
// Angle reduction: splits a nonnegative angle into quadrant, fold and radians Q0.30.
// Depends on psll_pkg.
module psll_reduce #(
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	output logic [29:0] x,
	output logic [1:0]  q,
	output logic        fold
);

	localparam logic [31:0] QUARTER = 32'd90 << ANGLE_FRAC_BITS;
	localparam logic [31:0] EIGHTH  = 32'd45 << ANGLE_FRAC_BITS;

	logic [63:0] est_s1;
	logic [31:0] a_s1, a_s2, pq_s2, r_s3, r_s4;
	logic [1:0]  q_s2, q_s3, q_s4, q_s5, q_s6;
	logic [29:0] xdeg_s5, x_s6;
	logic        fold_s5, fold_s6;
	logic [31:0] qe;
	logic [63:0] rad;

	// Whole degrees times 2^32/90 give the quadrant count, at most one short.
	assign qe  = est_s1[63:32];
	assign rad = 64'(xdeg_s5) * 64'(psll_pkg::DEG2RAD_Q32);

	always_ff @(posedge clk) begin
		if (en) begin
			est_s1  <= 64'(a >> ANGLE_FRAC_BITS) * 64'(psll_pkg::RECIP_90);
			a_s1    <= a;
			pq_s2   <= qe * QUARTER;
			q_s2    <= qe[1:0];
			a_s2    <= a_s1;
			r_s3    <= a_s2 - pq_s2;
			q_s3    <= q_s2;
			if (r_s3 >= QUARTER) begin
				r_s4 <= r_s3 - QUARTER;
				q_s4 <= q_s3 + 2'd1;
			end else begin
				r_s4 <= r_s3;
				q_s4 <= q_s3;
			end
			fold_s5 <= r_s4 > EIGHTH;
			xdeg_s5 <= (r_s4 > EIGHTH) ? 30'(QUARTER - r_s4) : 30'(r_s4);
			q_s5    <= q_s4;
			x_s6    <= 30'(rad >> (ANGLE_FRAC_BITS + 2));
			fold_s6 <= fold_s5;
			q_s6    <= q_s5;
		end
	end

	assign x    = x_s6;
	assign q    = q_s6;
	assign fold = fold_s6;

endmodule

FILE: src/psll_horner_cell.sv
// One Horner step t' = 1 - floor(z*t / 2^30) / DIV over three pipeline stages.
// Depends on psll_pkg.
module psll_horner_cell #(
	parameter int unsigned DIV = 2
) (
	input  logic        clk,
	input  logic        en,
	input  logic [29:0] z_in,
	input  logic [30:0] t_in,
	output logic [29:0] z_out,
	output logic [30:0] t_out
);

	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIV);

	logic [59:0] p_s1;
	logic [29:0] z_s1, z_s2, z_s3, v_s2;
	logic [61:0] e_s2;
	logic [30:0] t_s3;
	logic [29:0] qe;
	logic [31:0] rem;
	logic [29:0] qc;

	// The reciprocal estimate is low by at most one; the remainder fixes it.
	assign qe  = e_s2[61:32];
	assign rem = 32'(v_s2) - 32'(qe * DIV);
	assign qc  = (rem >= DIV) ? qe + 30'd1 : qe;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= 60'(z_in) * 60'(t_in);
			z_s1 <= z_in;
			v_s2 <= p_s1[59:30];
			e_s2 <= 62'(p_s1[59:30]) * 62'(RECIP);
			z_s2 <= z_s1;
			t_s3 <= psll_pkg::Q30_ONE - 31'(qc);
			z_s3 <= z_s2;
		end
	end

	assign z_out = z_s3;
	assign t_out = t_s3;

endmodule

FILE: src/psll_trig.sv
// Sine and cosine of an angle in [0, pi/4] radians Q0.30 by chains of Horner cells.
// Depends on psll_pkg, psll_horner_cell and psll_delay.
module psll_trig (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [29:0] x,
	output logic [30:0] sin_x,
	output logic [30:0] cos_x
);

	localparam int unsigned SIN_PAD =
		psll_pkg::CELL_LAT * (psll_pkg::COS_TERMS - psll_pkg::SIN_TERMS) - 1;

	logic [29:0] z_s1, x_s1, x_dly;
	logic [29:0] cz [psll_pkg::COS_TERMS+1];
	logic [30:0] ct [psll_pkg::COS_TERMS+1];
	logic [29:0] sz [psll_pkg::SIN_TERMS+1];
	logic [30:0] st [psll_pkg::SIN_TERMS+1];
	logic [30:0] sin_q;
	logic [59:0] sq;
	logic [60:0] sp;

	assign sq = 60'(x) * 60'(x);
	assign sp = 61'(x_dly) * 61'(st[psll_pkg::SIN_TERMS]);

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1  <= sq[59:30];
			x_s1  <= x;
			sin_q <= 31'(sp >> 30);
		end
	end

	assign cz[0] = z_s1;
	assign ct[0] = psll_pkg::Q30_ONE;
	assign sz[0] = z_s1;
	assign st[0] = psll_pkg::Q30_ONE;

	for (genvar gi = 0; gi < psll_pkg::COS_TERMS; gi++) begin : g_cos
		psll_horner_cell #(.DIV(psll_pkg::COS_DIV[gi])) u_cell (
			.clk   (clk),
			.en    (en),
			.z_in  (cz[gi]),
			.t_in  (ct[gi]),
			.z_out (cz[gi+1]),
			.t_out (ct[gi+1])
		);
	end

	for (genvar gi = 0; gi < psll_pkg::SIN_TERMS; gi++) begin : g_sin
		psll_horner_cell #(.DIV(psll_pkg::SIN_DIV[gi])) u_cell (
			.clk   (clk),
			.en    (en),
			.z_in  (sz[gi]),
			.t_in  (st[gi]),
			.z_out (sz[gi+1]),
			.t_out (st[gi+1])
		);
	end

	psll_delay #(.WIDTH(30), .DEPTH(psll_pkg::CELL_LAT * psll_pkg::SIN_TERMS)) u_x_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      (x_s1),
		.q      (x_dly)
	);

	psll_delay #(.WIDTH(31), .DEPTH(SIN_PAD)) u_sin_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      (sin_q),
		.q      (sin_x)
	);

	assign cos_x = ct[psll_pkg::COS_TERMS];

endmodule

FILE: src/psll_div_cell.sv
// One restoring division step: shifts in a numerator bit, produces one quotient bit.
// Depends on nothing.
module psll_div_cell (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] rem_in,
	input  logic [47:0] nq_in,
	input  logic [30:0] d_in,
	output logic [31:0] rem_out,
	output logic [47:0] nq_out,
	output logic [30:0] d_out
);

	logic [32:0] sh;
	logic        ge;

	assign sh = {rem_in, nq_in[47]};
	assign ge = sh >= 33'(d_in);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= ge ? 32'(sh - 33'(d_in)) : sh[31:0];
			nq_out  <= {nq_in[46:0], ge};
			d_out   <= d_in;
		end
	end

endmodule

FILE: src/psll_axis.sv
// One map axis: r times trig, pole offset, times inverse image size, saturation.
// Depends on psll_pkg.
module psll_axis #(
	parameter int OUT_FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                en,
	input  logic [47:0]         r,
	input  logic [30:0]         tm,
	input  logic                tn,
	input  psll_pkg::axis_cfg_t cfg,
	output logic [31:0]         val,
	output logic                sat
);

	localparam int SH = 32 - OUT_FRAC_BITS;

	logic [62:0] hi_s1;
	logic [30:0] lo_s1;
	logic [47:0] m_s2, mag_s4;
	logic [49:0] v_s3, offx;
	logic [63:0] hi_s5, sum_s6, p;
	logic [31:0] lo_s5, val_s7;
	logic        tn_s1, tn_s2, neg_s4, neg_s5, neg_s6, sat_s7;
	logic [46:0] lo_p;
	logic [47:0] lo2_p;
	logic [63:0] m_sum;

	assign lo_p  = 47'(r[15:0]) * 47'(tm);
	assign lo2_p = 48'(mag_s4[15:0]) * 48'(cfg.inv);
	assign m_sum = 64'(hi_s1) + 64'(lo_s1);
	assign offx  = 50'(cfg.off) << 12;
	assign p     = sum_s6 >> SH;

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s1  <= 63'(r[47:16]) * 63'(tm);
			lo_s1  <= 31'(lo_p >> 16);
			tn_s1  <= tn;
			m_s2   <= 48'(m_sum >> 14);
			tn_s2  <= tn_s1;
			v_s3   <= tn_s2 ? offx - 50'(m_s2) : offx + 50'(m_s2);
			neg_s4 <= v_s3[49];
			mag_s4 <= v_s3[49] ? 48'(-v_s3) : v_s3[47:0];
			hi_s5  <= 64'(mag_s4[47:16]) * 64'(cfg.inv);
			lo_s5  <= 32'(lo2_p >> 16);
			neg_s5 <= neg_s4;
			sum_s6 <= hi_s5 + 64'(lo_s5);
			neg_s6 <= neg_s5;
			if (!neg_s6) begin
				if (p > 64'h7FFF_FFFF) begin
					val_s7 <= 32'h7FFF_FFFF;
					sat_s7 <= 1'b1;
				end else begin
					val_s7 <= p[31:0];
					sat_s7 <= 1'b0;
				end
			end else begin
				if (p > 64'h8000_0000) begin
					val_s7 <= 32'h8000_0000;
					sat_s7 <= 1'b1;
				end else begin
					val_s7 <= -p[31:0];
					sat_s7 <= 1'b0;
				end
			end
		end
	end

	assign val = val_s7;
	assign sat = sat_s7;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for polar_stereo_latlong_to_xy_core.
// Depends on psll_pkg and the core; drives both handshake channels and the APB-style port.
module tb_top;

	typedef struct {
		logic signed [23:0] lat;
		logic signed [24:0] lon;
		bit                 sat_known;
		bit                 sat_val;
	} point_row_t;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic        sat;
	} xy_result_t;

	localparam logic [63:0] ONE_Q30   = 64'd1 << 30;
	localparam logic [63:0] DEG_RAD   = 64'd74961321;
	localparam logic [63:0] RAD_LIMIT = 64'd1 << 47;
	localparam logic [63:0] DEG90     = 64'd90 << 16;
	localparam logic [63:0] DEG45     = 64'd45 << 16;
	localparam int          CYCLE_LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [23:0] lat_deg = '0;
	logic signed [24:0] lon_deg = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] x_rel, y_rel;
	logic saturated;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [psll_pkg::CFG_ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	logic [63:0] gain_r, xoff_r, yoff_r, xinv_r, yinv_r;
	xy_result_t pending_xy[$];
	int errors = 0;
	int results_seen = 0;
	int cycles = 0;
	int send_idle_pct = 19;
	int recv_idle_pct = 19;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	polar_stereo_latlong_to_xy_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .lat_deg(lat_deg), .lon_deg(lon_deg),
		.out_valid(out_valid), .out_ready(out_ready),
		.x_rel(x_rel), .y_rel(y_rel), .saturated(saturated),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] scaled_mul(logic [63:0] a, logic [63:0] b, int sh);
		logic [63:0] hi, lo;
		hi = (a >> 16) * b;
		lo = ((a & 64'hFFFF) * b) >> 16;
		return (hi + lo) >> (sh - 16);
	endfunction

	function automatic logic [63:0] taylor_sin(logic [63:0] x);
		logic [63:0] z, t;
		z = (x * x) >> 30;
		t = ONE_Q30;
		t = ONE_Q30 - ((z * t) >> 30) / 110;
		t = ONE_Q30 - ((z * t) >> 30) / 72;
		t = ONE_Q30 - ((z * t) >> 30) / 42;
		t = ONE_Q30 - ((z * t) >> 30) / 20;
		t = ONE_Q30 - ((z * t) >> 30) / 6;
		return (x * t) >> 30;
	endfunction

	function automatic logic [63:0] taylor_cos(logic [63:0] x);
		logic [63:0] z, t;
		z = (x * x) >> 30;
		t = ONE_Q30;
		t = ONE_Q30 - ((z * t) >> 30) / 132;
		t = ONE_Q30 - ((z * t) >> 30) / 90;
		t = ONE_Q30 - ((z * t) >> 30) / 56;
		t = ONE_Q30 - ((z * t) >> 30) / 30;
		t = ONE_Q30 - ((z * t) >> 30) / 12;
		t = ONE_Q30 - ((z * t) >> 30) / 2;
		return t;
	endfunction

	function automatic void angle_trig(input logic [63:0] a, output logic [63:0] sm,
			output bit sn, output logic [63:0] cm, output bit cn);
		logic [63:0] q, rem, s0, c0, x;
		q = (a / DEG90) & 64'd3;
		rem = a % DEG90;
		if (rem <= DEG45) begin
			x = (rem * DEG_RAD) >> 18;
			s0 = taylor_sin(x);
			c0 = taylor_cos(x);
		end else begin
			x = ((DEG90 - rem) * DEG_RAD) >> 18;
			s0 = taylor_cos(x);
			c0 = taylor_sin(x);
		end
		case (q)
			64'd0: begin sm = s0; sn = 0; cm = c0; cn = 0; end
			64'd1: begin sm = c0; sn = 0; cm = s0; cn = 1; end
			64'd2: begin sm = s0; sn = 1; cm = c0; cn = 1; end
			default: begin sm = c0; sn = 1; cm = s0; cn = 0; end
		endcase
	endfunction

	function automatic logic [31:0] axis_coord(logic [63:0] r, logic [63:0] tm, bit tn,
			logic [63:0] off, logic [63:0] inv, inout bit sat);
		logic [63:0] m, mag, p;
		logic signed [63:0] v;
		m = scaled_mul(r, tm, 30);
		v = $signed(off << 12);
		v = tn ? v - $signed(m) : v + $signed(m);
		mag = (v < 0) ? -v : v;
		p = scaled_mul(mag, inv, 32);
		if (v >= 0) begin
			if (p > 64'h7FFF_FFFF) begin p = 64'h7FFF_FFFF; sat = 1; end
			return p[31:0];
		end
		if (p > 64'h8000_0000) begin p = 64'h8000_0000; sat = 1; end
		return 32'((-p) & 64'hFFFF_FFFF);
	endfunction

	function automatic xy_result_t project_point(logic signed [23:0] lat,
			logic signed [24:0] lon);
		xy_result_t res;
		logic [63:0] alat, alon, ts, tc, ls, lc, r;
		bit tsn, tcn, lsn, lcn, sat;
		sat = 0;
		alat = (lat < 0) ? -64'(lat) : 64'(lat);
		alon = (lon < 0) ? -64'(lon) : 64'(lon);
		if (alat > DEG90)
			alat = DEG90;
		angle_trig(DEG90 - alat, ts, tsn, tc, tcn);
		if (tc == 0) begin
			r = RAD_LIMIT;
			sat = 1;
		end else begin
			r = (gain_r * ts) / tc;
			if (r > RAD_LIMIT) begin r = RAD_LIMIT; sat = 1; end
		end
		angle_trig(alon, ls, lsn, lc, lcn);
		if (lon < 0)
			lsn = !lsn;
		res.x = axis_coord(r, ls, lsn, xoff_r, xinv_r, sat);
		res.y = axis_coord(r, lc, lcn, yoff_r, yinv_r, sat);
		res.sat = sat;
		return res;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel = 1; penable = 0; pwrite = 1;
		paddr = {idx, 2'b00}; pwdata = val;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
		case (idx)
			psll_pkg::REG_RADIAL_GAIN: gain_r = val;
			psll_pkg::REG_X_OFFSET:    xoff_r = val[15:0];
			psll_pkg::REG_Y_OFFSET:    yoff_r = val[15:0];
			psll_pkg::REG_X_INV_SIZE:  xinv_r = val;
			default:                   yinv_r = val;
		endcase
	endtask

	task automatic load_setting(logic [31:0] g, logic [15:0] xo, logic [15:0] yo,
			logic [31:0] xi, logic [31:0] yi);
		write_reg(psll_pkg::REG_RADIAL_GAIN, g);
		write_reg(psll_pkg::REG_X_OFFSET, {16'd0, xo});
		write_reg(psll_pkg::REG_Y_OFFSET, {16'd0, yo});
		write_reg(psll_pkg::REG_X_INV_SIZE, xi);
		write_reg(psll_pkg::REG_Y_INV_SIZE, yi);
	endtask

	task automatic drain_pipeline();
		while (pending_xy.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// Holds valid and the payload until the transaction is accepted.
	task automatic send_point(logic signed [23:0] lat, logic signed [24:0] lon,
			bit sat_known, bit sat_val);
		xy_result_t e;
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid = 0;
		end
		@(negedge clk);
		in_valid = 1; lat_deg = lat; lon_deg = lon;
		do @(posedge clk); while (!in_ready);
		e = project_point(lat, lon);
		if (sat_known)
			e.sat = sat_val;
		pending_xy.push_back(e);
	endtask

	task automatic random_points(int n);
		logic signed [23:0] lat;
		logic signed [24:0] lon;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: lat = 24'($urandom);
				1: lat = 24'($urandom_range(2000) - 1000);
				2: lat = 24'(($urandom_range(1) ? 1 : -1) * (5898240 - $urandom_range(3000)));
				default: lat = 24'($urandom_range(11796480) - 5898240);
			endcase
			if ($urandom_range(4) == 0)
				lon = 25'($urandom);
			else
				lon = 25'($urandom_range(23592960) - 11796480);
			send_point(lat, lon, 0, 0);
		end
		@(negedge clk);
		in_valid = 0;
	endtask

	point_row_t dir_rows[] = '{
		'{24'sd0, 25'sd0, 1, 1},
		'{24'sd5898240, 25'sd0, 1, 0},
		'{-24'sd5898240, 25'sd0, 1, 0},
		'{24'sd5898241, 25'sd100, 1, 0},
		'{24'sh7FFFFF, 25'sd0, 1, 0},
		'{24'sh800000, 25'sd0, 1, 0},
		'{24'sd0, 25'sd11796480, 1, 1},
		'{24'sd0, -25'sd11796480, 1, 1},
		'{24'sd1, 25'sd0, 0, 0},
		'{-24'sd1, 25'sd5898240, 0, 0},
		'{-24'sd4587520, 25'sd2949120, 0, 0},
		'{-24'sd4587520, -25'sd2949120, 0, 0},
		'{-24'sd4587520, 25'sd5898240, 0, 0},
		'{-24'sd4587520, 25'sd8847360, 0, 0},
		'{-24'sd4587520, 25'sd11796480, 0, 0},
		'{-24'sd4587520, 25'sh0FFFFFF, 0, 0},
		'{-24'sd4587520, 25'sh1000000, 0, 0},
		'{-24'sd2949120, 25'sd2949121, 0, 0},
		'{-24'sd2949120, 25'sd2949119, 0, 0},
		'{-24'sd3000000, 25'sd15000000, 0, 0},
		'{-24'sd3000000, -25'sd15000000, 0, 0},
		'{-24'sd65536, 25'sd1234567, 0, 0}
	};

	// Receiver: random back-pressure plus one long hold-off on request.
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			out_ready = 0;
			repeat (300) @(negedge clk);
			hold_done = 1;
		end
		out_ready = ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		xy_result_t e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $realtime, pending_xy.size());
			$display("polar_stereo_latlong_to_xy_core: mismatch");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_xy.size() == 0) begin
				errors++;
				$display("%0t: unexpected result x=%h y=%h sat=%b", $realtime,
					x_rel, y_rel, saturated);
			end else begin
				e = pending_xy.pop_front();
				if (x_rel !== e.x) begin
					errors++;
					$display("%0t: x_rel expected %h actual %h", $realtime, e.x, x_rel);
				end
				if (y_rel !== e.y) begin
					errors++;
					$display("%0t: y_rel expected %h actual %h", $realtime, e.y, y_rel);
				end
				if (saturated !== e.sat) begin
					errors++;
					$display("%0t: saturated expected %b actual %b", $realtime,
						e.sat, saturated);
				end
			end
		end
	end

	initial begin
		gain_r = psll_pkg::RST_RADIAL_GAIN;
		xoff_r = psll_pkg::RST_X_OFFSET;
		yoff_r = psll_pkg::RST_Y_OFFSET;
		xinv_r = psll_pkg::RST_X_INV_SIZE;
		yinv_r = psll_pkg::RST_Y_INV_SIZE;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Reset defaults first; saturation flags of these rows are known by eye.
		foreach (dir_rows[i])
			send_point(dir_rows[i].lat, dir_rows[i].lon, dir_rows[i].sat_known,
				dir_rows[i].sat_val);
		@(negedge clk);
		in_valid = 0;
		random_points(200);

		// Long hold-off while the sender keeps offering, so the pipeline backs up.
		hold_req = 1;
		random_points(150);
		drain_pipeline();

		load_setting(32'd0, 16'd0, 16'd0, 32'd1, 32'd1);
		random_points(80);
		drain_pipeline();

		load_setting(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		random_points(100);
		drain_pipeline();

		// Zero inverse sizes through the port's full data width.
		load_setting(32'd65536, 16'd1234, 16'd4321, 32'd0, 32'd0);
		random_points(60);
		drain_pipeline();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_setting($urandom, 16'($urandom), 16'($urandom), $urandom, $urandom);
		random_points(160);
		drain_pipeline();

		send_idle_pct = 19;
		recv_idle_pct = 19;
		load_setting($urandom_range(200000000), 16'($urandom), 16'($urandom),
			$urandom_range(30000000, 1), $urandom_range(30000000, 1));
		random_points(180);
		drain_pipeline();

		$display("Covered directed edge cases and random points over six register settings.");
		$display("%0d results checked, %0d errors.", results_seen, errors);
		if (errors == 0 && pending_xy.size() == 0)
			$display("polar_stereo_latlong_to_xy_core: match");
		else
			$display("polar_stereo_latlong_to_xy_core: mismatch");
		$finish;
	end

endmodule

FILE: polar_stereo_latlong_to_xy_core.f
src/psll_pkg.sv
src/psll_delay.sv
src/psll_reduce.sv
src/psll_horner_cell.sv
src/psll_trig.sv
src/psll_div_cell.sv
src/psll_axis.sv
src/polar_stereo_latlong_to_xy_core.sv
sim/tb_top.sv
